>>> hdl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [1:0] SHAPE_8X8 = 2'd0;
  localparam logic [1:0] SHAPE_8X4 = 2'd1;
  localparam logic [1:0] SHAPE_4X4 = 2'd2;

  localparam logic REG_TILE_SHAPE  = 1'b0;
  localparam logic REG_IMAGE_WIDTH = 1'b1;

  localparam logic [1:0]  TILE_SHAPE_RST  = SHAPE_4X4;
  localparam logic [10:0] IMAGE_WIDTH_RST = 11'd1024;

  localparam logic [7:0] FINE_Y_BIAS = 8'h80;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [19:0] entry_index;
    logic [7:0]  coarse_x;
    logic [7:0]  coarse_y;
    logic [2:0]  fine_x;
    logic [7:0]  fine_y_biased;
  } out_item_t;

  typedef struct packed {
    logic [19:0] entry_index;
    logic [7:0]  coarse_y;
    logic [2:0]  fine_x;
    logic [7:0]  fine_y_biased;
  } side_t;

endpackage

>>> hdl/tts_front.sv
`timescale 1ns / 1ps

module tts_front #(
  parameter int WW  = 11,
  parameter int AW  = 9,
  parameter int LW  = 20,
  parameter int DW  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  tts_pkg::in_item_t data_i,
  output logic              ready_o,
  input  logic [1:0]        shape_i,
  input  logic [WW-1:0]     width_i,
  input  logic [AW-1:0]     blocks_x_i,
  output logic              valid_o,
  output logic [DW-1:0]     dividend_o,
  output tts_pkg::side_t    side_o,
  input  logic              ready_i
);
  import tts_pkg::*;

  localparam int PW = 8 + AW + 1;

  logic              valid_r;
  logic [DW-1:0]     dividend_r;
  side_t             side_r;
  logic [DW-1:0]     dividend_nxt;
  side_t             side_nxt;
  logic [LW-1:0]     lin;
  logic [PW-1:0]     pos;
  logic [2:0]        fine_row;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    lin = LW'(LW'(data_i.pixel_y) * LW'(width_i)) + LW'(data_i.pixel_x);
    pos = PW'(PW'(data_i.pixel_y[9:2]) * PW'(blocks_x_i)) + PW'(data_i.pixel_x[9:2]);
    side_nxt.entry_index = 20'({pos, data_i.pixel_y[1:0], data_i.pixel_x[1:0]});
    unique case (shape_i)
      SHAPE_8X8: begin
        dividend_nxt     = DW'(lin >> 6);
        fine_row         = lin[5:3];
        side_nxt.coarse_y = 8'(data_i.pixel_y >> 3);
        side_nxt.fine_x   = data_i.pixel_x[2:0];
      end
      SHAPE_8X4: begin
        dividend_nxt     = DW'(lin >> 5);
        fine_row         = {1'b0, lin[4:3]};
        side_nxt.coarse_y = 8'(data_i.pixel_y >> 2);
        side_nxt.fine_x   = data_i.pixel_x[2:0];
      end
      default: begin
        dividend_nxt     = DW'(lin >> 4);
        fine_row         = {1'b0, lin[3:2]};
        side_nxt.coarse_y = 8'(data_i.pixel_y >> 2);
        side_nxt.fine_x   = {1'b0, data_i.pixel_x[1:0]};
      end
    endcase
    side_nxt.fine_y_biased = 8'(fine_row) - data_i.pixel_y[7:0] + FINE_Y_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      dividend_r <= dividend_nxt;
      side_r     <= side_nxt;
    end
  end

  assign valid_o    = valid_r;
  assign dividend_o = dividend_r;
  assign side_o     = side_r;

endmodule

>>> hdl/tts_mod_cell.sv
`timescale 1ns / 1ps

module tts_mod_cell #(
  parameter int AW  = 9,
  parameter int DW  = 16,
  parameter int BIT = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [AW-1:0]  divisor_i,
  input  logic           valid_i,
  input  logic [AW-1:0]  rem_i,
  input  logic [DW-1:0]  dividend_i,
  input  tts_pkg::side_t side_i,
  output logic           ready_o,
  output logic           valid_o,
  output logic [AW-1:0]  rem_o,
  output logic [DW-1:0]  dividend_o,
  output tts_pkg::side_t side_o,
  input  logic           ready_i
);
  import tts_pkg::*;

  logic           valid_r;
  logic [AW-1:0]  rem_r;
  logic [DW-1:0]  dividend_r;
  side_t          side_r;
  logic [AW:0]    trial;
  logic [AW-1:0]  rem_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    trial = {rem_i, dividend_i[BIT]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    rem_nxt = trial[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_r      <= rem_nxt;
      dividend_r <= dividend_i;
      side_r     <= side_i;
    end
  end

  assign valid_o    = valid_r;
  assign rem_o      = rem_r;
  assign dividend_o = dividend_r;
  assign side_o     = side_r;

endmodule

>>> hdl/tiled_texture_swizzle_lut_entry.sv
// Pipeline: one front stage plus one remainder cell per bit of the tile number.
// Throughput: one item per cycle while out_stall is low; each cell folds one bit
//   of the tile number into the remainder that gives the tile column.
// Reset: synchronous, active low; tile_shape returns to 4x4, image_width to 1024
//   and the pipeline empties. No clearing pass.
`timescale 1ns / 1ps

module tiled_texture_swizzle_lut_entry #(
  parameter int MAX_WIDTH = tts_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tts_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > 11) ? WW : 11;
  localparam int AW = $clog2((MAX_WIDTH + 3) / 4 + 1);
  localparam int LW = $clog2(1023 * (MAX_WIDTH + 1) + 1);
  localparam int DW = LW - 4;

  logic [1:0]    tile_shape_r;
  logic [10:0]   image_width_r;
  logic [CW-1:0] w_raw;
  logic [WW-1:0] w_eff;
  logic [WW:0]   w_p3;
  logic [WW:0]   w_p7;
  logic [AW-1:0] blocks_x;
  logic [AW-1:0] across;

  logic          vld   [0:DW];
  logic          rdy   [0:DW];
  logic [AW-1:0] rem   [0:DW];
  logic [DW-1:0] dvd   [0:DW];
  side_t         side  [0:DW];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_shape_r  <= TILE_SHAPE_RST;
      image_width_r <= IMAGE_WIDTH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TILE_SHAPE:  tile_shape_r  <= pwdata[1:0];
        REG_IMAGE_WIDTH: image_width_r <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TILE_SHAPE:  prdata = {30'd0, tile_shape_r};
      REG_IMAGE_WIDTH: prdata = {21'd0, image_width_r};
    endcase
  end

  always_comb begin
    w_raw = CW'(image_width_r);
    if (w_raw == '0) begin
      w_raw = CW'(1);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_raw = CW'(MAX_WIDTH);
    end
    w_eff    = WW'(w_raw);
    w_p3     = {1'b0, w_eff} + (WW+1)'(3);
    w_p7     = {1'b0, w_eff} + (WW+1)'(7);
    blocks_x = AW'(w_p3 >> 2);
    unique case (tile_shape_r)
      SHAPE_8X8, SHAPE_8X4: across = AW'(w_p7 >> 3);
      default:              across = AW'(w_p3 >> 2);
    endcase
  end

  tts_front #(
    .WW (WW),
    .AW (AW),
    .LW (LW),
    .DW (DW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_valid),
    .data_i     (in_data),
    .ready_o    (rdy[0]),
    .shape_i    (tile_shape_r),
    .width_i    (w_eff),
    .blocks_x_i (blocks_x),
    .valid_o    (vld[0]),
    .dividend_o (dvd[0]),
    .side_o     (side[0]),
    .ready_i    (rdy[1])
  );

  assign rem[0]  = '0;
  assign in_stall = !rdy[0];

  for (genvar i = 0; i < DW; i++) begin : g_cell
    if (i < DW - 1) begin : g_mid
      tts_mod_cell #(
        .AW  (AW),
        .DW  (DW),
        .BIT (DW - 1 - i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor_i  (across),
        .valid_i    (vld[i]),
        .rem_i      (rem[i]),
        .dividend_i (dvd[i]),
        .side_i     (side[i]),
        .ready_o    (rdy[i+1]),
        .valid_o    (vld[i+1]),
        .rem_o      (rem[i+1]),
        .dividend_o (dvd[i+1]),
        .side_o     (side[i+1]),
        .ready_i    (rdy[i+2])
      );
    end else begin : g_last
      tts_mod_cell #(
        .AW  (AW),
        .DW  (DW),
        .BIT (DW - 1 - i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor_i  (across),
        .valid_i    (vld[i]),
        .rem_i      (rem[i]),
        .dividend_i (dvd[i]),
        .side_i     (side[i]),
        .ready_o    (rdy[i+1]),
        .valid_o    (vld[i+1]),
        .rem_o      (rem[i+1]),
        .dividend_o (dvd[i+1]),
        .side_o     (side[i+1]),
        .ready_i    (!out_stall)
      );
    end
  end

  assign out_valid              = vld[DW];
  assign out_data.entry_index   = side[DW].entry_index;
  assign out_data.coarse_x      = 8'(rem[DW]);
  assign out_data.coarse_y      = side[DW].coarse_y;
  assign out_data.fine_x        = side[DW].fine_x;
  assign out_data.fine_y_biased = side[DW].fine_y_biased;

endmodule

>>> test/tiled_texture_swizzle_lut_entry_tb.sv
`timescale 1ns / 1ps

module tiled_texture_swizzle_lut_entry_tb;
  import tts_pkg::*;

  localparam logic [1:0] SHAPE_SPARE = 2'd3;
  localparam int N_DIR = 20;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [1:0]  shape;
    logic [10:0] width;
    in_item_t    px;
    logic        known;
    out_item_t   want;
  } pixel_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  out_item_t   pending_entries[$];
  int          bad_entries = 0;
  int          accepted_pixels = 0;
  bit          calm = 1'b0;
  logic [1:0]  cur_shape = TILE_SHAPE_RST;
  logic [10:0] cur_width = IMAGE_WIDTH_RST;

  pixel_case_t dir_cases [N_DIR] = '{
    '{SHAPE_4X4, 11'd1024, '{10'd0, 10'd0}, 1'b1, '{20'd0, 8'd0, 8'd0, 3'd0, 8'h80}},
    '{SHAPE_4X4, 11'd1024, '{10'd1023, 10'd1023}, 1'b1,
      '{20'hFFFFF, 8'd255, 8'd255, 3'd3, 8'h84}},
    '{SHAPE_4X4, 11'd1024, '{10'd0, 10'd1}, 1'b1, '{20'd4, 8'd64, 8'd0, 3'd0, 8'd127}},
    '{SHAPE_4X4, 11'd1024, '{10'd1023, 10'd0}, 1'b0, '0},
    '{SHAPE_8X8, 11'd1024, '{10'd0, 10'd0}, 1'b1, '{20'd0, 8'd0, 8'd0, 3'd0, 8'h80}},
    '{SHAPE_8X8, 11'd1024, '{10'd1023, 10'd1023}, 1'b0, '0},
    '{SHAPE_8X8, 11'd1024, '{10'd685, 10'd342}, 1'b0, '0},
    '{SHAPE_8X4, 11'd1024, '{10'd342, 10'd685}, 1'b0, '0},
    '{SHAPE_8X4, 11'd1024, '{10'd7, 10'd3}, 1'b0, '0},
    '{SHAPE_SPARE, 11'd1024, '{10'd5, 10'd9}, 1'b0, '0},
    '{SHAPE_SPARE, 11'd17, '{10'd20, 10'd2}, 1'b0, '0},
    '{SHAPE_8X8, 11'd0, '{10'd0, 10'd0}, 1'b1, '{20'd0, 8'd0, 8'd0, 3'd0, 8'h80}},
    '{SHAPE_8X8, 11'd0, '{10'd1023, 10'd1023}, 1'b0, '0},
    '{SHAPE_4X4, 11'd2047, '{10'd1023, 10'd1023}, 1'b1,
      '{20'hFFFFF, 8'd255, 8'd255, 3'd3, 8'h84}},
    '{SHAPE_8X4, 11'd1025, '{10'd512, 10'd700}, 1'b0, '0},
    '{SHAPE_4X4, 11'd1, '{10'd0, 10'd1023}, 1'b0, '0},
    '{SHAPE_8X8, 11'd1, '{10'd1023, 10'd0}, 1'b0, '0},
    '{SHAPE_8X4, 11'd9, '{10'd8, 10'd8}, 1'b0, '0},
    '{SHAPE_4X4, 11'd1000, '{10'd999, 10'd999}, 1'b0, '0},
    '{SHAPE_8X8, 11'd3, '{10'd2, 10'd511}, 1'b0, '0}
  };

  tiled_texture_swizzle_lut_entry DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_width(logic [10:0] width);
    int unsigned w;
    w = (width == 0) ? 1 : width;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic out_item_t predict_entry(logic [1:0] shape, logic [10:0] width,
                                              in_item_t px);
    int unsigned w, x, y, tw, th, tsz, across, lin, tile_col, fine_row, blk_x, off;
    out_item_t r;
    x = px.pixel_x;
    y = px.pixel_y;
    w = clamp_width(width);
    case (shape)
      SHAPE_8X8: begin
        tw = 8;
        th = 8;
      end
      SHAPE_8X4: begin
        tw = 8;
        th = 4;
      end
      default: begin
        tw = 4;
        th = 4;
      end
    endcase
    tsz = tw * th;
    across = (w + tw - 1) / tw;
    lin = y * w + x;
    tile_col = (lin / tsz) % across;
    fine_row = (lin % tsz) / tw;
    blk_x = (w + 3) >> 2;
    off = (((y >> 2) * blk_x + (x >> 2)) << 5) + (y & 3) * 8 + (x & 3) * 2;
    r.entry_index   = 20'(off >> 1);
    r.coarse_x      = 8'(tile_col);
    r.coarse_y      = 8'(y / th);
    r.fine_x        = 3'(x % tw);
    r.fine_y_biased = 8'(fine_row - y + FINE_Y_BIAS);
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_entries();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setup(input logic [1:0] shape, input logic [10:0] width);
    drain_entries();
    write_reg({REG_TILE_SHAPE, 2'b00}, ($urandom() & ~32'h3) | 32'(shape));
    write_reg({REG_IMAGE_WIDTH, 2'b00}, ($urandom() & ~32'h7FF) | 32'(width));
    cur_shape = shape;
    cur_width = width;
  endtask

  task automatic send_pixel(input in_item_t px, input logic known, input out_item_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_entries.push_back(known ? want : predict_entry(cur_shape, cur_width, px));
    accepted_pixels++;
  endtask

  always @(posedge clk) begin : check_entry
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        bad_entries++;
        if (bad_entries <= 10) $display("unexpected entry %h", out_data);
      end else begin
        want = pending_entries.pop_front();
        if (out_data.entry_index !== want.entry_index || out_data.coarse_x !== want.coarse_x
            || out_data.coarse_y !== want.coarse_y || out_data.fine_x !== want.fine_x
            || out_data.fine_y_biased !== want.fine_y_biased) begin
          bad_entries++;
          if (bad_entries <= 10)
            $display("entry mismatch: want %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     want.entry_index, want.coarse_x, want.coarse_y, want.fine_x,
                     want.fine_y_biased, out_data.entry_index, out_data.coarse_x,
                     out_data.coarse_y, out_data.fine_x, out_data.fine_y_biased);
        end
      end
    end
  end

  initial begin : stall_driver
    int burst;
    bit stall_now;
    bit held;
    burst = 0;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && accepted_pixels >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end
      if (calm) begin
        stall_now = 1'b0;
      end else if (burst > 0) begin
        stall_now = 1'b1;
        burst--;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_now = 1'b1;
        burst = $urandom_range(0, 6);
      end else begin
        stall_now = 1'b0;
      end
      out_stall <= stall_now;
    end
  end

  initial begin : stimulus
    int p, k, i, lim;
    logic [1:0] shp;
    logic [10:0] wid;
    in_item_t px;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < N_DIR; k++) begin
      if (dir_cases[k].shape != cur_shape || dir_cases[k].width != cur_width)
        apply_setup(dir_cases[k].shape, dir_cases[k].width);
      send_pixel(dir_cases[k].px, dir_cases[k].known, dir_cases[k].want);
    end
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          shp = SHAPE_8X8;
          wid = 11'd1;
        end
        1: begin
          shp = SHAPE_8X4;
          wid = 11'd1024;
        end
        2: begin
          shp = SHAPE_SPARE;
          wid = 11'd2047;
        end
        3: begin
          shp = SHAPE_4X4;
          wid = 11'd0;
        end
        4: begin
          shp = SHAPE_8X8;
          wid = 11'd1024;
        end
        5: begin
          shp = SHAPE_8X4;
          wid = 11'd1;
        end
        default: begin
          shp = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: wid = 11'($urandom_range(1, 1024));
            1: wid = 11'($urandom_range(1, 16));
            2: wid = 11'($urandom_range(1000, 2047));
            default: wid = 11'($urandom_range(0, 2047));
          endcase
        end
      endcase
      apply_setup(shp, wid);
      calm = (p == PHASES - 1);
      lim = clamp_width(cur_width);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) px.pixel_x = 10'($urandom_range(0, 1023));
        else px.pixel_x = 10'($urandom_range(0, lim - 1));
        px.pixel_y = 10'($urandom_range(0, 1023));
        send_pixel(px, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    for (i = 0; i < 20000 && pending_entries.size() != 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    bad_entries += pending_entries.size();
    if (bad_entries == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
